@@ design/qmtm_pkg.sv @@
// ----------------------------------------------------------------------------
// qmtm_pkg
// Types, codes and constants shared by the quad motor throttle mixer.
// ----------------------------------------------------------------------------
package qmtm_pkg;

	localparam int unsigned NUM_MOTORS = 4;
	localparam int unsigned NUM_DIRS   = 8;

	localparam logic [11:0] ARM_THROTTLE   = 12'd1350;
	localparam logic [11:0] LOW_LIMIT      = 12'd1000;
	localparam logic [11:0] HIGH_LIMIT     = 12'd2000;
	localparam logic [11:0] IDLE_RESET     = 12'd1000;
	localparam logic [7:0]  STEP_RESET     = 8'd10;
	localparam logic [12:0] STRENGTH_SCALE = 13'd20;

	typedef enum logic {
		OP_THROTTLE,
		OP_STEER
	} operation_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_DOWN,
		CMD_UP,
		CMD_TOGGLE
	} throttle_cmd_t;

	typedef enum logic {
		REG_IDLE_THROTTLE,
		REG_THROTTLE_STEP
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SGN_ZERO,
		SGN_POS,
		SGN_NEG
	} sign_t;

	typedef logic [11:0]        throttle_t;
	typedef logic signed [13:0] offset_t;
	typedef logic [13:0]        motor_t;
	typedef offset_t            offset_arr_t [NUM_MOTORS];
	typedef motor_t             motor_arr_t [NUM_MOTORS];
	typedef sign_t              sign_row_t [NUM_MOTORS];

	// offset sign per direction sector, motors a..d
	localparam sign_row_t SIGN_TABLE [NUM_DIRS] = '{
		'{SGN_NEG,  SGN_POS,  SGN_POS,  SGN_NEG },
		'{SGN_NEG,  SGN_ZERO, SGN_POS,  SGN_ZERO},
		'{SGN_NEG,  SGN_NEG,  SGN_POS,  SGN_POS },
		'{SGN_ZERO, SGN_NEG,  SGN_ZERO, SGN_POS },
		'{SGN_POS,  SGN_NEG,  SGN_NEG,  SGN_POS },
		'{SGN_POS,  SGN_ZERO, SGN_NEG,  SGN_ZERO},
		'{SGN_POS,  SGN_POS,  SGN_NEG,  SGN_NEG },
		'{SGN_ZERO, SGN_POS,  SGN_ZERO, SGN_NEG }
	};

endpackage

@@ design/qmtm_mixer.sv @@
// ----------------------------------------------------------------------------
// qmtm_mixer
// Adds the throttle to each motor offset and clamps negative sums at zero.
// ----------------------------------------------------------------------------
module qmtm_mixer
	import qmtm_pkg::*;
(
	input  throttle_t   throttle,
	input  offset_arr_t offsets,
	output motor_arr_t  motors
);

	logic signed [14:0] sum [NUM_MOTORS];

	always_comb begin
		for (int m = 0; m < NUM_MOTORS; m++) begin
			sum[m] = $signed({3'b000, throttle}) + $signed({offsets[m][13], offsets[m]});
			motors[m] = sum[m][14] ? '0 : sum[m][13:0];
		end
	end

endmodule

@@ design/quad_motor_throttle_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_motor_throttle_mixer
// Throttle and steering mixer for four motors with an armed flag.
// ----------------------------------------------------------------------------
// Each accepted item produces exactly one result item: the item is captured
// in an input register, the state update and the four clamped motor sums
// are worked out in one pass, and the result is held in an output register.
// A new item is accepted every cycle while results are taken; in_stall rises
// only when both registers are full and out_stall is high. Configuration
// writes are always ready and take effect on items that follow.
module quad_motor_throttle_mixer
	import qmtm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [1:0]  throttle_cmd,
	input  logic [2:0]  direction,
	input  logic [7:0]  strength,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] motor_a,
	output logic [13:0] motor_b,
	output logic [13:0] motor_c,
	output logic [13:0] motor_d,
	output logic        is_armed,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	throttle_t     idle_throttle_q;
	logic [7:0]    throttle_step_q;
	throttle_t     throttle_q;
	logic          armed_q;
	offset_arr_t   offsets_q;

	logic          valid_s1;
	operation_t    operation_s1;
	throttle_cmd_t cmd_s1;
	logic [2:0]    direction_s1;
	logic [7:0]    strength_s1;

	logic          valid_s2;
	motor_arr_t    motors_s2;
	logic          armed_s2;

	logic          advance_s2;
	logic          load_s1;
	throttle_t     throttle_nxt;
	logic          armed_nxt;
	offset_arr_t   offsets_nxt;
	logic [12:0]   k;
	offset_t       k_pos;
	motor_arr_t    motors_nxt;

	assign advance_s2 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s2;
	assign load_s1    = in_valid && !in_stall;
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_throttle_q <= IDLE_RESET;
			throttle_step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IDLE_THROTTLE: idle_throttle_q <= cfg_data;
				REG_THROTTLE_STEP: throttle_step_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			operation_s1 <= operation_t'(operation);
			cmd_s1       <= throttle_cmd_t'(throttle_cmd);
			direction_s1 <= direction;
			strength_s1  <= strength;
		end
	end

	// state update for the item in the input register
	assign k     = 13'(strength_s1) * STRENGTH_SCALE;
	assign k_pos = offset_t'({1'b0, k});

	always_comb begin
		throttle_nxt = throttle_q;
		armed_nxt    = armed_q;
		offsets_nxt  = offsets_q;
		case (operation_s1)
			OP_THROTTLE: begin
				case (cmd_s1)
					CMD_TOGGLE: begin
						throttle_nxt = armed_q ? idle_throttle_q : ARM_THROTTLE;
						armed_nxt    = !armed_q;
					end
					CMD_DOWN: begin
						if (throttle_q > LOW_LIMIT)
							throttle_nxt = throttle_q - throttle_t'(throttle_step_q);
					end
					CMD_UP: begin
						if (throttle_q < HIGH_LIMIT)
							throttle_nxt = throttle_q + throttle_t'(throttle_step_q);
					end
					default: ;
				endcase
			end
			OP_STEER: begin
				if (armed_q) begin
					for (int m = 0; m < NUM_MOTORS; m++) begin
						case (SIGN_TABLE[direction_s1][m])
							SGN_POS: offsets_nxt[m] = k_pos;
							SGN_NEG: offsets_nxt[m] = -k_pos;
							default: offsets_nxt[m] = '0;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	qmtm_mixer u_mixer (
		.throttle (throttle_nxt),
		.offsets  (offsets_nxt),
		.motors   (motors_nxt)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= IDLE_RESET;
			armed_q    <= 1'b0;
			for (int m = 0; m < NUM_MOTORS; m++)
				offsets_q[m] <= '0;
		end else if (advance_s2) begin
			throttle_q <= throttle_nxt;
			armed_q    <= armed_nxt;
			offsets_q  <= offsets_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2) begin
			motors_s2 <= motors_nxt;
			armed_s2  <= armed_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign motor_a   = motors_s2[0];
	assign motor_b   = motors_s2[1];
	assign motor_c   = motors_s2[2];
	assign motor_d   = motors_s2[3];
	assign is_armed  = armed_s2;

endmodule

@@ tb/sv/quad_motor_throttle_mixer_test.sv @@
// ----------------------------------------------------------------------------
// quad_motor_throttle_mixer_test
// Drives throttle and steering items into the mixer under random idling and
// stalls, predicts the four motor levels and the armed flag for every
// accepted item, and checks each result against that prediction in order.
// ----------------------------------------------------------------------------
import qmtm_pkg::*;

class mixer_scoreboard;
	typedef struct {
		motor_t motor [4];
		logic   armed;
	} motor_levels_t;

	throttle_t     idle_level;
	logic [7:0]    step;
	throttle_t     throttle;
	logic          armed;
	int            offset [4];
	motor_levels_t expected_levels [$];
	int unsigned   mismatches;
	string         motor_name [4];

	function new();
		idle_level = IDLE_RESET;
		step       = STEP_RESET;
		throttle   = IDLE_RESET;
		armed      = 1'b0;
		offset     = '{0, 0, 0, 0};
		mismatches = 0;
		motor_name = '{"motor_a", "motor_b", "motor_c", "motor_d"};
	endfunction

	function void write_reg(cfg_reg_t index, logic [11:0] data);
		if (index == REG_IDLE_THROTTLE)
			idle_level = data;
		else
			step = data[7:0];
	endfunction

	function void predict_levels(operation_t op, throttle_cmd_t cmd, logic [2:0] dir,
			logic [7:0] strength);
		int            k;
		int            sum;
		int            m;
		motor_levels_t levels;
		if (op == OP_THROTTLE) begin
			case (cmd)
				CMD_TOGGLE: begin
					throttle = armed ? idle_level : ARM_THROTTLE;
					armed = !armed;
				end
				CMD_DOWN: if (throttle > LOW_LIMIT) throttle = throttle - throttle_t'(step);
				CMD_UP:   if (throttle < HIGH_LIMIT) throttle = throttle + throttle_t'(step);
				default: ;
			endcase
		end else if (armed) begin
			k = int'(strength) * int'(STRENGTH_SCALE);
			case (dir)
				3'd0: offset = '{-k,  k,  k, -k};
				3'd1: offset = '{-k,  0,  k,  0};
				3'd2: offset = '{-k, -k,  k,  k};
				3'd3: offset = '{ 0, -k,  0,  k};
				3'd4: offset = '{ k, -k, -k,  k};
				3'd5: offset = '{ k,  0, -k,  0};
				3'd6: offset = '{ k,  k, -k, -k};
				default: offset = '{ 0,  k,  0, -k};
			endcase
		end
		for (m = 0; m < 4; m++) begin
			sum = int'(throttle) + offset[m];
			levels.motor[m] = (sum < 0) ? motor_t'(0) : motor_t'(sum);
		end
		levels.armed = armed;
		expected_levels.push_back(levels);
	endfunction

	function void check_result(motor_t a, motor_t b, motor_t c, motor_t d, logic armed_out);
		motor_levels_t want;
		motor_t        got [4];
		int            m;
		got = '{a, b, c, d};
		if (expected_levels.size() == 0) begin
			$error("result with none expected: %0d %0d %0d %0d armed %0b",
				a, b, c, d, armed_out);
			mismatches++;
			return;
		end
		want = expected_levels.pop_front();
		for (m = 0; m < 4; m++)
			if (got[m] !== want.motor[m]) begin
				$error("%s: expected %0d, actual %0d", motor_name[m], want.motor[m], got[m]);
				mismatches++;
			end
		if (armed_out !== want.armed) begin
			$error("is_armed: expected %0b, actual %0b", want.armed, armed_out);
			mismatches++;
		end
	endfunction

	function int pending();
		return expected_levels.size();
	endfunction
endclass

module quad_motor_throttle_mixer_test;
	localparam int HOLD_CYCLES  = 90;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 225;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [1:0]  throttle_cmd = 2'd0;
	logic [2:0]  direction = 3'd0;
	logic [7:0]  strength = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [13:0] motor_a;
	logic [13:0] motor_b;
	logic [13:0] motor_c;
	logic [13:0] motor_d;
	logic        is_armed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [11:0] cfg_data = 12'd0;

	int send_idle_pct = 35;
	int recv_stall_pct = 69;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	mixer_scoreboard levels_sb = new();

	quad_motor_throttle_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.throttle_cmd (throttle_cmd),
		.direction    (direction),
		.strength     (strength),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.motor_a      (motor_a),
		.motor_b      (motor_b),
		.motor_c      (motor_c),
		.motor_d      (motor_d),
		.is_armed     (is_armed),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				levels_sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (out_valid && !out_stall)
				levels_sb.check_result(motor_a, motor_b, motor_c, motor_d, is_armed);
			if (in_valid && !in_stall)
				levels_sb.predict_levels(operation_t'(operation),
					throttle_cmd_t'(throttle_cmd), direction, strength);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_item(input operation_t op, input throttle_cmd_t cmd,
			input logic [2:0] dir, input logic [7:0] str);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		throttle_cmd <= cmd;
		direction    <= dir;
		strength     <= str;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random_item(input bit climb);
		operation_t    op;
		throttle_cmd_t cmd;
		logic [2:0]    dir;
		logic [7:0]    str;
		int            pick;
		op = ($urandom_range(99) < 40) ? OP_STEER : OP_THROTTLE;
		pick = $urandom_range(99);
		if (pick < 4)
			cmd = CMD_TOGGLE;
		else if (pick < 14)
			cmd = CMD_NONE;
		else if (pick < 74)
			cmd = climb ? CMD_UP : CMD_DOWN;
		else
			cmd = climb ? CMD_DOWN : CMD_UP;
		dir = 3'($urandom_range(7));
		pick = $urandom_range(9);
		if (pick == 0)
			str = 8'd0;
		else if (pick == 1)
			str = 8'd255;
		else
			str = 8'($urandom_range(255));
		send_item(op, cmd, dir, str);
	endtask

	task automatic write_config(input logic [11:0] idle_level, input logic [7:0] step);
		cfg_valid <= 1'b1;
		cfg_index <= REG_IDLE_THROTTLE;
		cfg_data  <= idle_level;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_THROTTLE_STEP;
		cfg_data  <= {4'd0, step};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (levels_sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int  phase;
		int  n;
		bit  climb;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_THROTTLE, CMD_NONE,   3'd7, 8'd255);
		send_item(OP_STEER,    CMD_NONE,   3'd0, 8'd255);
		send_item(OP_THROTTLE, CMD_DOWN,   3'd0, 8'd0);
		send_item(OP_THROTTLE, CMD_UP,     3'd0, 8'd0);
		send_item(OP_THROTTLE, CMD_DOWN,   3'd5, 8'd90);
		send_item(OP_THROTTLE, CMD_TOGGLE, 3'd0, 8'd0);
		send_item(OP_STEER,    CMD_NONE,   3'd0, 8'd255);
		send_item(OP_STEER,    CMD_NONE,   3'd1, 8'd0);
		send_item(OP_STEER,    CMD_NONE,   3'd2, 8'd128);
		send_item(OP_STEER,    CMD_NONE,   3'd3, 8'd127);
		send_item(OP_STEER,    CMD_NONE,   3'd4, 8'd1);
		send_item(OP_STEER,    CMD_NONE,   3'd5, 8'd200);
		send_item(OP_STEER,    CMD_NONE,   3'd6, 8'd85);
		send_item(OP_STEER,    CMD_NONE,   3'd7, 8'd170);
		send_item(OP_STEER,    CMD_TOGGLE, 3'd2, 8'd67);
		send_item(OP_THROTTLE, CMD_UP,     3'd7, 8'd255);
		send_item(OP_THROTTLE, CMD_TOGGLE, 3'd0, 8'd0);
		send_item(OP_STEER,    CMD_NONE,   3'd6, 8'd255);
		send_item(OP_THROTTLE, CMD_UP,     3'd0, 8'd0);
		send_item(OP_THROTTLE, CMD_TOGGLE, 3'd0, 8'd0);
		send_item(OP_STEER,    CMD_NONE,   3'd4, 8'd255);
		send_item(OP_THROTTLE, CMD_NONE,   3'd0, 8'd0);
		drain_results();

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase < 2) begin
				send_idle_pct = 35;
				recv_stall_pct <= 69;
			end else if (phase < 4) begin
				send_idle_pct = 69;
				recv_stall_pct <= 35;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
			case (phase)
				0: write_config(12'd4095, 8'd255);
				1: write_config(12'd0, 8'd0);
				2: write_config(12'($urandom_range(4095)), 8'($urandom_range(255, 1)));
				3: write_config(12'd1000, 8'd1);
				4: write_config(12'($urandom_range(4095)), 8'($urandom_range(255)));
				default: write_config(12'd2000, 8'd128);
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					climb = 1'($urandom_range(1));
				send_random_item(climb);
			end
			if (phase == 1) begin
				hold_asks <= hold_asks + 1;
				send_idle_pct = 0;
				repeat (24) send_random_item(1'b1);
			end
			drain_results();
		end

		if (levels_sb.mismatches == 0 && levels_sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
